FILE: sv/incp_pkg.sv
`timescale 1ns / 1ps

package incp_pkg;

    localparam int COORD_BITS_DEF = 16;

    // two's complement sign codes of the determinant
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

endpackage

FILE: sv/incp_query_if.sv
`timescale 1ns / 1ps

interface incp_query_if #(
    parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic                         border_counts;

    modport source (
        output valid, a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y, border_counts,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y, border_counts,
        output ready
    );
endinterface

FILE: sv/incp_result_if.sv
`timescale 1ns / 1ps

interface incp_result_if;
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic signed [1:0] det_sign;

    modport source (
        output valid, inside_res, det_sign,
        input  ready
    );

    modport sink (
        input  valid, inside_res, det_sign,
        output ready
    );
endinterface

FILE: sv/incp_lift.sv
`timescale 1ns / 1ps

// Stage 1: offsets of a, b, c from the query point.
// Stage 2: lifted squared distances and the three 2x2 minors.
module incp_lift #(
    parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    incp_query_if.sink                             query,
    output logic                                   dn_valid,
    input  logic                                   dn_ready,
    output logic [2:0][2*COORD_BITS:0]             lift,
    output logic [2:0][2*COORD_BITS+1:0]           minor,
    output logic                                   border
);
    localparam int DW = COORD_BITS + 1;
    localparam int LW = 2 * COORD_BITS + 1;
    localparam int MW = 2 * COORD_BITS + 2;

    logic s1_en;
    logic s2_en;
    logic s1_vld_reg;
    logic s1_vld_next;
    logic s2_vld_reg;
    logic s2_vld_next;

    logic signed [DW-1:0] dx_reg [3];
    logic signed [DW-1:0] dx_next [3];
    logic signed [DW-1:0] dy_reg [3];
    logic signed [DW-1:0] dy_next [3];
    logic                 border1_reg;

    logic [LW-1:0]        lift_reg [3];
    logic [LW-1:0]        lift_next [3];
    logic signed [MW-1:0] sq_sum [3];
    logic signed [MW-1:0] minor_reg [3];
    logic signed [MW-1:0] minor_next [3];
    logic                 border2_reg;

    assign s2_en       = !s2_vld_reg || dn_ready;
    assign s1_en       = !s1_vld_reg || s2_en;
    assign query.ready = s1_en;
    assign s1_vld_next = s1_en ? query.valid : s1_vld_reg;
    assign s2_vld_next = s2_en ? s1_vld_reg : s2_vld_reg;

    always_comb
    begin
        dx_next[0] = DW'(query.a_x) - DW'(query.q_x);
        dy_next[0] = DW'(query.a_y) - DW'(query.q_y);
        dx_next[1] = DW'(query.b_x) - DW'(query.q_x);
        dy_next[1] = DW'(query.b_y) - DW'(query.q_y);
        dx_next[2] = DW'(query.c_x) - DW'(query.q_x);
        dy_next[2] = DW'(query.c_y) - DW'(query.q_y);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_sum[i] = MW'(dx_reg[i]) * MW'(dx_reg[i]) + MW'(dy_reg[i]) * MW'(dy_reg[i]);
            lift_next[i] = sq_sum[i][LW-1:0];
        end
        // each lane pairs with the minor of the other two points
        minor_next[0] = MW'(dx_reg[1]) * MW'(dy_reg[2]) - MW'(dy_reg[1]) * MW'(dx_reg[2]);
        minor_next[1] = MW'(dx_reg[0]) * MW'(dy_reg[2]) - MW'(dy_reg[0]) * MW'(dx_reg[2]);
        minor_next[2] = MW'(dx_reg[0]) * MW'(dy_reg[1]) - MW'(dy_reg[0]) * MW'(dx_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            border1_reg <= query.border_counts;
        end
        if (s2_en)
        begin
            lift_reg    <= lift_next;
            minor_reg   <= minor_next;
            border2_reg <= border1_reg;
        end
    end

    assign dn_valid = s2_vld_reg;
    assign border   = border2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lift[i]  = lift_reg[i];
            minor[i] = minor_reg[i];
        end
    end
endmodule

FILE: sv/incp_mul.sv
`timescale 1ns / 1ps

// Wide lift x minor products, split at half width.
// Stage A: four partial products per lane. Stage B: shift and add them.
module incp_mul #(
    parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [2:0][2*COORD_BITS:0]    lift,
    input  logic [2:0][2*COORD_BITS+1:0]  minor,
    input  logic                          border_in,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [2:0][4*COORD_BITS+2:0]  prod,
    output logic                          border_out
);
    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int H   = COORD_BITS + 1;
    localparam int LHW = LW - H;
    localparam int MHW = MW - H;
    localparam int PW  = LW + MW;
    localparam int W0  = 2 * H;
    localparam int W1  = H + 1 + MHW;
    localparam int W2  = LHW + H;
    localparam int W3  = LHW + 1 + MHW;

    logic sa_en;
    logic sb_en;
    logic sa_vld_reg;
    logic sa_vld_next;
    logic sb_vld_reg;
    logic sb_vld_next;
    logic border_a_reg;
    logic border_b_reg;

    assign sb_en       = !sb_vld_reg || dn_ready;
    assign sa_en       = !sa_vld_reg || sb_en;
    assign up_ready    = sa_en;
    assign sa_vld_next = sa_en ? up_valid : sa_vld_reg;
    assign sb_vld_next = sb_en ? sa_vld_reg : sb_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
        end
        else
        begin
            sa_vld_reg <= sa_vld_next;
            sb_vld_reg <= sb_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sa_en)
        begin
            border_a_reg <= border_in;
        end
        if (sb_en)
        begin
            border_b_reg <= border_a_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic [H-1:0]          ll;
        logic [LHW-1:0]        lh;
        logic [H-1:0]          ml;
        logic signed [MHW-1:0] mh;

        logic [W0-1:0]         pp_ll_reg;
        logic [W0-1:0]         pp_ll_next;
        logic signed [W1-1:0]  pp_lm_reg;
        logic signed [W1-1:0]  pp_lm_next;
        logic [W2-1:0]         pp_hl_reg;
        logic [W2-1:0]         pp_hl_next;
        logic signed [W3-1:0]  pp_hh_reg;
        logic signed [W3-1:0]  pp_hh_next;
        logic [PW-1:0]         prod_reg;
        logic [PW-1:0]         prod_next;

        assign ll = lift[i][H-1:0];
        assign lh = lift[i][LW-1:H];
        assign ml = minor[i][H-1:0];
        assign mh = $signed(minor[i][MW-1:H]);

        assign pp_ll_next = W0'(ll) * W0'(ml);
        assign pp_lm_next = W1'($signed({1'b0, ll})) * W1'(mh);
        assign pp_hl_next = W2'(lh) * W2'(ml);
        assign pp_hh_next = W3'($signed({1'b0, lh})) * W3'(mh);

        // sign-extend the signed partials, zero-extend the others
        assign prod_next = PW'(pp_ll_reg)
                         + (PW'(pp_lm_reg) << H)
                         + (PW'(pp_hl_reg) << H)
                         + (PW'(pp_hh_reg) << (2 * H));

        always_ff @(posedge clk)
        begin
            if (sa_en)
            begin
                pp_ll_reg <= pp_ll_next;
                pp_lm_reg <= pp_lm_next;
                pp_hl_reg <= pp_hl_next;
                pp_hh_reg <= pp_hh_next;
            end
            if (sb_en)
            begin
                prod_reg <= prod_next;
            end
        end

        assign prod[i] = prod_reg;
    end

    assign dn_valid   = sb_vld_reg;
    assign border_out = border_b_reg;
endmodule

FILE: sv/incp_sign.sv
`timescale 1ns / 1ps

// Stage C: det = P0 - P1 + P2. Stage D: sign, border rule, output register.
module incp_sign #(
    parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [2:0][4*COORD_BITS+2:0]  prod,
    input  logic                          border_in,
    incp_result_if.source                 result
);
    localparam int PW   = 4 * COORD_BITS + 3;
    localparam int DETW = PW + 2;

    logic sc_en;
    logic sd_en;
    logic sc_vld_reg;
    logic sc_vld_next;
    logic sd_vld_reg;
    logic sd_vld_next;

    logic signed [DETW-1:0] det_reg;
    logic signed [DETW-1:0] det_next;
    logic                   border_c_reg;

    logic                   det_neg;
    logic                   det_zero;
    logic                   inside_reg;
    logic                   inside_next;
    logic [1:0]             sign_reg;
    logic [1:0]             sign_next;

    assign sd_en       = !sd_vld_reg || result.ready;
    assign sc_en       = !sc_vld_reg || sd_en;
    assign up_ready    = sc_en;
    assign sc_vld_next = sc_en ? up_valid : sc_vld_reg;
    assign sd_vld_next = sd_en ? sc_vld_reg : sd_vld_reg;

    assign det_next = DETW'($signed(prod[0])) - DETW'($signed(prod[1]))
                    + DETW'($signed(prod[2]));

    assign det_neg  = det_reg[DETW-1];
    assign det_zero = (det_reg == '0);

    always_comb
    begin
        if (det_neg)
        begin
            sign_next = incp_pkg::SIGN_NEG;
        end
        else if (det_zero)
        begin
            sign_next = incp_pkg::SIGN_ZERO;
        end
        else
        begin
            sign_next = incp_pkg::SIGN_POS;
        end
        inside_next = border_c_reg ? !det_neg : (!det_neg && !det_zero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
            sd_vld_reg <= 1'b0;
        end
        else
        begin
            sc_vld_reg <= sc_vld_next;
            sd_vld_reg <= sd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_en)
        begin
            det_reg      <= det_next;
            border_c_reg <= border_in;
        end
        if (sd_en)
        begin
            inside_reg <= inside_next;
            sign_reg   <= sign_next;
        end
    end

    assign result.valid      = sd_vld_reg;
    assign result.inside_res = inside_reg;
    assign result.det_sign   = $signed(sign_reg);
endmodule

FILE: sv/incircle_predicate.sv
`timescale 1ns / 1ps

// Incircle test: is query point q inside the circle through a, b, c?
// query  (sink, valid/ready): a, b, c, q as signed COORD_BITS coordinates
//        and border_counts, which makes a zero determinant count as inside.
// result (source, valid/ready): inside_res and det_sign (-1, 0, +1), the
//        exact sign of the 4x4 lifted determinant, one per request, in order.
// A request passes six register stages on its way to the result port:
// offsets, lift and minors, partial products, product sum, determinant sum,
// sign. They take one request every cycle unless the result stalls; the
// widest logic is the half-width partial product multipliers of the lift x
// minor terms.
// Each stage holds a valid bit and loads when it is empty or the stage after
// it moves, so a stalled result register holds its data while earlier empty
// stages keep filling; query.ready drops only once every stage is full.
// Reset clears all valid bits; no result is shown until a new request
// passes through.
module incircle_predicate #(
    parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    incp_query_if.sink    query,
    incp_result_if.source result
);
    localparam int LW = 2 * COORD_BITS + 1;
    localparam int MW = 2 * COORD_BITS + 2;
    localparam int PW = LW + MW;

    logic                 lift_valid;
    logic                 lift_ready;
    logic [2:0][LW-1:0]   lift;
    logic [2:0][MW-1:0]   minor;
    logic                 lift_border;

    logic                 mul_valid;
    logic                 mul_ready;
    logic [2:0][PW-1:0]   prod;
    logic                 mul_border;

    incp_lift #(
        .COORD_BITS (COORD_BITS)
    ) u_lift (
        .clk      (clk),
        .rst_n    (rst_n),
        .query    (query),
        .dn_valid (lift_valid),
        .dn_ready (lift_ready),
        .lift     (lift),
        .minor    (minor),
        .border   (lift_border)
    );

    incp_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (lift_valid),
        .up_ready   (lift_ready),
        .lift       (lift),
        .minor      (minor),
        .border_in  (lift_border),
        .dn_valid   (mul_valid),
        .dn_ready   (mul_ready),
        .prod       (prod),
        .border_out (mul_border)
    );

    incp_sign #(
        .COORD_BITS (COORD_BITS)
    ) u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (mul_valid),
        .up_ready  (mul_ready),
        .prod      (prod),
        .border_in (mul_border),
        .result    (result)
    );
endmodule

FILE: sv/incp_checker.sv
`timescale 1ns / 1ps

module incp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       q_valid,
    input logic       q_ready,
    input logic       r_valid,
    input logic       r_ready,
    input logic       inside_res,
    input logic [1:0] det_sign
);
    // a positive determinant is inside under either border rule
    a_pos_inside : assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && det_sign == incp_pkg::SIGN_POS) |-> inside_res)
        else $error("positive determinant reported outside");

    // a negative determinant is never inside
    a_neg_outside : assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && det_sign == incp_pkg::SIGN_NEG) |-> !inside_res)
        else $error("negative determinant reported inside");

    // with the result register empty the pipeline must take a request
    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> q_ready)
        else $error("request refused while the output is empty");

    // a stalled result holds
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> (r_valid && $stable(inside_res) && $stable(det_sign)))
        else $error("stalled result changed");
endmodule

bind incircle_predicate incp_checker u_incp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (query.valid),
    .q_ready    (query.ready),
    .r_valid    (result.valid),
    .r_ready    (result.ready),
    .inside_res (result.inside_res),
    .det_sign   (result.det_sign)
);
